// ----- src/arpc_pkg.sv -----
// Shared types and constants for the ARP cache receive engine.
// Used by arpc_classify, arpc_queue, arpc_engine and the top level.
`default_nettype none

package arpc_pkg;

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int LEN_W      = 11;
    localparam int OP_W       = 16;
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 176;

    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 11'd42;
    localparam logic [OP_W-1:0]  OPCODE_REQUEST  = 16'd1;
    localparam logic [OP_W-1:0]  OPCODE_REPLY    = 16'd2;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FRAME  = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOOKUP,
        KIND_LEARN,
        KIND_NOP
    } cmd_kind_t;

    // One classified transaction, as handed from front to back.
    typedef struct packed {
        cmd_kind_t        kind;
        logic [IP_W-1:0]  ip;       // query address or sender address
        logic [MAC_W-1:0] mac;      // sender hardware address
        logic [MAC_W-1:0] src_mac;  // Ethernet source of the frame
        logic             reply;    // request aimed at this station
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/arpc_classify.sv -----
// Front-end decode: turns one input transaction into a command for the back end.
// Depends on arpc_pkg.
`default_nettype none

module arpc_classify
    import arpc_pkg::*;
(
    input  wire logic             func,
    input  wire logic [IP_W-1:0]  query_ip,
    input  wire logic [LEN_W-1:0] frame_length,
    input  wire logic [OP_W-1:0]  arp_opcode,
    input  wire logic [IP_W-1:0]  sender_ip,
    input  wire logic [MAC_W-1:0] sender_mac,
    input  wire logic [IP_W-1:0]  target_ip,
    input  wire logic [MAC_W-1:0] eth_source_mac,
    input  wire logic [IP_W-1:0]  own_ip,
    output cmd_t                  cmd
);

    logic long_enough;
    logic is_request;
    logic is_reply;

    assign long_enough = (frame_length >= MIN_FRAME_BYTES);
    assign is_request  = (arp_opcode == OPCODE_REQUEST);
    assign is_reply    = (arp_opcode == OPCODE_REPLY);

    always_comb
    begin
        cmd.ip      = sender_ip;
        cmd.mac     = sender_mac;
        cmd.src_mac = eth_source_mac;
        cmd.reply   = 1'b0;
        cmd.kind    = KIND_NOP;
        if (func == FUNC_LOOKUP)
        begin
            cmd.kind = KIND_LOOKUP;
            cmd.ip   = query_ip;
        end
        else if (long_enough && (is_request || is_reply))
        begin
            cmd.kind  = KIND_LEARN;
            cmd.reply = is_request && (target_ip == own_ip);
        end
    end

endmodule

`default_nettype wire

// ----- src/arpc_queue.sv -----
// Two-entry command queue between the decode front and the table back end.
// Depends on arpc_pkg.
`default_nettype none

module arpc_queue
    import arpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/arpc_engine.sv -----
// Back end: address table, compare/execute sequencer and result register.
// Depends on arpc_pkg.
`default_nettype none

module arpc_engine
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmd_t              cmd,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   hit,
    output logic [MAC_W-1:0]       found_mac,
    output logic                   send_reply,
    output logic [MAC_W-1:0]       reply_dest_mac,
    output logic [MAC_W-1:0]       reply_target_mac,
    output logic [IP_W-1:0]        reply_target_ip
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic {
        ST_CMP,
        ST_EXEC
    } state_t;

    function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    state_t                   state_reg;
    cmd_t                     cmd_reg;
    logic [TABLE_ENTRIES-1:0] match_reg;
    logic [TABLE_ENTRIES-1:0] match_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]          ip_reg [TABLE_ENTRIES];
    logic [MAC_W-1:0]         mac_mem [TABLE_ENTRIES];
    logic [MAC_W-1:0]         rd_mac_reg;

    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic                     out_reply_reg;
    logic [MAC_W-1:0]         out_dmac_reg;
    logic [MAC_W-1:0]         out_tmac_reg;
    logic [IP_W-1:0]          out_tip_reg;

    logic                     take_cmd;
    logic                     exec_go;
    logic                     any_match;
    logic                     any_free;
    logic [IDX_W-1:0]         match_idx;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         wr_idx;
    logic                     learn;
    logic                     new_entry;

    // Compare the queue head against every valid entry in parallel.
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (ip_reg[i] == cmd.ip);
        end
    end

    assign cmd_ready = (state_reg == ST_CMP);
    assign take_cmd  = cmd_valid && cmd_ready;
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || res_ready);

    assign any_match = |match_reg;
    assign any_free  = ~&valid_reg;
    assign match_idx = first_set(match_reg);
    assign free_idx  = first_set(~valid_reg);
    assign learn     = exec_go && (cmd_reg.kind == KIND_LEARN);
    assign new_entry = learn && !any_match;
    // Update in place, else lowest free slot, else evict entry 0.
    assign wr_idx    = any_match ? match_idx : (any_free ? free_idx : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CMP;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_reply_reg <= 1'b0;
            out_dmac_reg  <= '0;
            out_tmac_reg  <= '0;
            out_tip_reg   <= '0;
            cmd_reg       <= '0;
            match_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CMP:
                begin
                    if (take_cmd)
                    begin
                        cmd_reg   <= cmd;
                        match_reg <= match_next;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_go)
                    begin
                        out_valid_reg <= 1'b1;
                        out_hit_reg   <= (cmd_reg.kind == KIND_LOOKUP) && any_match;
                        out_reply_reg <= cmd_reg.reply;
                        out_dmac_reg  <= cmd_reg.reply ? cmd_reg.src_mac : '0;
                        out_tmac_reg  <= cmd_reg.reply ? cmd_reg.mac : '0;
                        out_tip_reg   <= cmd_reg.reply ? cmd_reg.ip : '0;
                        if (new_entry)
                        begin
                            valid_reg[wr_idx] <= 1'b1;
                        end
                        state_reg <= ST_CMP;
                    end
                end
                default:
                begin
                    state_reg <= ST_CMP;
                end
            endcase
        end
    end

    // Address table: IP words compared in place, MAC words in a memory.
    always_ff @(posedge clk)
    begin
        if (new_entry)
        begin
            ip_reg[wr_idx] <= cmd_reg.ip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (learn)
        begin
            mac_mem[wr_idx] <= cmd_reg.mac;
        end
        if (exec_go)
        begin
            rd_mac_reg <= mac_mem[match_idx];
        end
    end

    assign res_valid        = out_valid_reg;
    assign hit              = out_hit_reg;
    assign found_mac        = out_hit_reg ? rd_mac_reg : '0;
    assign send_reply       = out_reply_reg;
    assign reply_dest_mac   = out_dmac_reg;
    assign reply_target_mac = out_tmac_reg;
    assign reply_target_ip  = out_tip_reg;

endmodule

`default_nettype wire

// ----- src/arp_cache_receive_engine.sv -----
// Top level of the ARP cache receive engine: ports, own-address register,
// and the decode -> queue -> table engine chain. Depends on arpc_pkg and its modules.
//
//  Port group          Dir   Width  Contents
//  s_tvalid/tready     in    224/1  lookup or received ARP frame (s_tdata, s_tuser)
//  m_tvalid/tready     out   176/2  lookup result and reply request (m_tdata, m_tuser)
//  cfg_valid/ready     in    32     own IPv4 address write
//
// In the table engine each transaction passes a compare state, which checks the
// address against all entries and registers the match vector, then an execute
// state, which updates the table and loads the result register. The next compare
// has to see that update, so no new transaction is taken until execute is done.
// Reset clears all entry valid bits at once; unwritten MAC words are never output.
// A stalled m_tready holds the result; the engine then holds one more transaction and
// the two-entry queue takes two more, after which s_tready drops until m_tready returns.
`default_nettype none

module arp_cache_receive_engine
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] query_ip, [42:32] frame_length, [58:43] arp_opcode,
    // [90:59] sender_ip, [138:91] sender_mac, [170:139] target_ip,
    // [218:171] eth_source_mac, [223:219] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] func
    input  wire logic                  s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [47:0] found_mac, [95:48] reply_dest_mac, [143:96] reply_target_mac,
    // [175:144] reply_target_ip
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // [0] hit, [1] send_reply
    output logic [1:0]                 m_tuser,
    // Configuration write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IP_W-1:0]       cfg_data
);

    logic [IP_W-1:0]  own_ip_reg;
    cmd_t             front_cmd;
    cmd_t             back_cmd;
    logic             back_valid;
    logic             back_ready;
    logic             hit;
    logic             send_reply;
    logic [MAC_W-1:0] found_mac;
    logic [MAC_W-1:0] reply_dest_mac;
    logic [MAC_W-1:0] reply_target_mac;
    logic [IP_W-1:0]  reply_target_ip;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            own_ip_reg <= cfg_data;
        end
    end

    // Front: decode the transaction into a table command.
    arpc_classify u_classify (
        .func           (s_tuser),
        .query_ip       (s_tdata[31:0]),
        .frame_length   (s_tdata[42:32]),
        .arp_opcode     (s_tdata[58:43]),
        .sender_ip      (s_tdata[90:59]),
        .sender_mac     (s_tdata[138:91]),
        .target_ip      (s_tdata[170:139]),
        .eth_source_mac (s_tdata[218:171]),
        .own_ip         (own_ip_reg),
        .cmd            (front_cmd)
    );

    // Decouple intake from the table engine.
    arpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    // Back: compare, learn, and hold the result until taken.
    arpc_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (back_valid),
        .cmd_ready        (back_ready),
        .cmd              (back_cmd),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .hit              (hit),
        .found_mac        (found_mac),
        .send_reply       (send_reply),
        .reply_dest_mac   (reply_dest_mac),
        .reply_target_mac (reply_target_mac),
        .reply_target_ip  (reply_target_ip)
    );

    assign m_tdata = {reply_target_ip, reply_target_mac, reply_dest_mac, found_mac};
    assign m_tuser = {send_reply, hit};

endmodule

`default_nettype wire
